/* rtl/svcl_pkg.sv */
// ----------------------------------------------------------------------------
// svcl_pkg
// shared widths, register indexes, types and helpers of the voltage logger
// ----------------------------------------------------------------------------
package svcl_pkg;

  // field widths
  localparam int SAMPLE_W     = 13;
  localparam int FRAC_W       = 8;
  localparam int FIX_W        = SAMPLE_W + FRAC_W;
  localparam int WEIGHT_W     = 9;
  localparam int THR_W        = 13;
  localparam int TIME_W       = 32;
  localparam int LEVEL_IN_W   = 8;
  localparam int LEVEL_W      = 7;
  localparam int READ_INDEX_W = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // arithmetic constants
  localparam int WEIGHT_ONE = 1 << FRAC_W;
  localparam int MV_MAX     = (1 << SAMPLE_W) - 1;
  localparam int LEVEL_MAX  = 100;

  // log ring geometry
  localparam int LOG_DEPTH = 256;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int CMP_W     = (CNT_W > READ_INDEX_W) ? CNT_W : READ_INDEX_W;
  localparam int SUM_W     = CMP_W + 1;

  // item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD_MV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_TIMEOUT_S       = 2'd2;

  // configuration reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 9'd77;
  localparam logic [THR_W-1:0]    THR_RST     = 13'd10;
  localparam logic [TIME_W-1:0]   TIMEOUT_RST = 32'd1800;

  typedef struct packed {
    logic [TIME_W-1:0]   uptime;
    logic [SAMPLE_W-1:0] millivolts;
    logic [LEVEL_W-1:0]  level;
  } log_entry_t;

  typedef struct packed {
    logic              we;
    logic [LOG_AW-1:0] addr;
    log_entry_t        data;
  } log_wr_t;

  typedef struct packed {
    logic              re;
    logic [LOG_AW-1:0] addr;
  } log_rd_t;

  // fixed point to millivolts, round half up, clamp to the field range
  function automatic logic [SAMPLE_W-1:0] to_mv(input logic [FIX_W-1:0] fixed);
    logic [FIX_W:0] rounded;
    logic [SAMPLE_W:0] mv;
    rounded = {1'b0, fixed} + (FIX_W+1)'(1 << (FRAC_W - 1));
    mv = rounded[FIX_W:FRAC_W];
    if (mv > (SAMPLE_W+1)'(MV_MAX)) begin
      return SAMPLE_W'(MV_MAX);
    end
    return mv[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/svcl_ema.sv */
// ----------------------------------------------------------------------------
// svcl_ema
// one exponential moving average step in 13.8 fixed point
// ----------------------------------------------------------------------------
module svcl_ema import svcl_pkg::*; (
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [FIX_W-1:0]    old_fix,
  input  logic [SAMPLE_W-1:0] sample_mv,
  output logic [FIX_W-1:0]    new_fix
);

  localparam int ACC_W = WEIGHT_W + FIX_W;

  logic [WEIGHT_W-1:0] w_sat;
  logic [WEIGHT_W-1:0] w_inv;
  logic [FIX_W-1:0]    s_fix;
  logic [ACC_W-1:0]    acc;

  // weights above one count as one
  assign w_sat = (weight > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight;
  assign w_inv = WEIGHT_W'(WEIGHT_ONE) - w_sat;
  assign s_fix = {sample_mv, {FRAC_W{1'b0}}};

  assign acc = ACC_W'(w_sat) * ACC_W'(s_fix) + ACC_W'(w_inv) * ACC_W'(old_fix)
             + ACC_W'(1 << (FRAC_W - 1));

  // empty filter loads the sample directly
  assign new_fix = (old_fix == '0) ? s_fix : acc[FRAC_W +: FIX_W];

endmodule

/* rtl/svcl_log_ram.sv */
// ----------------------------------------------------------------------------
// svcl_log_ram
// ring log storage, one write and one registered read port
// ----------------------------------------------------------------------------
module svcl_log_ram import svcl_pkg::*; (
  input  logic       clk,
  input  log_wr_t    wr,
  input  log_rd_t    rd,
  output log_entry_t rd_data
);

  log_entry_t mem [LOG_DEPTH];
  log_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/smoothed_voltage_change_logger_unit.sv */
// ----------------------------------------------------------------------------
// smoothed_voltage_change_logger_unit
// voltage smoothing filter with change and timeout driven ring log
// ----------------------------------------------------------------------------
// Each transaction is either a voltage sample or a log read. A sample runs
// through an exponential moving average (weight out of 256, 13.8 fixed point)
// and appends an entry to a 256 entry ring log when the log is empty, when
// the filtered value moved by at least the threshold since the last entry,
// or when the timeout has passed. A read fetches an entry counted from the
// oldest one. The block takes one transaction every cycle while the result
// side does not stall; a result is offered once its transaction has moved
// from the input register into the result register. There are two register stages:
// the input register, where filter, decision and log write/read address are
// computed, then the result register, loaded at the same edge as the
// registered read port of the log memory. A stalled result holds the input
// register, so at most two transactions are in flight. The log needs no
// clearing pass after reset, since only written entries can ever be read.
// Configuration writes are always taken and should only be done while idle.
// ----------------------------------------------------------------------------
module smoothed_voltage_change_logger_unit import svcl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,

  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic [SAMPLE_W-1:0]     in_sample_mv,
  input  logic [LEVEL_IN_W-1:0]   in_charge_level,
  input  logic [TIME_W-1:0]       in_uptime_s,
  input  logic [READ_INDEX_W-1:0] in_read_index,

  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_logged,
  output logic [SAMPLE_W-1:0]     out_filtered_mv,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_entry_valid,
  output logic [TIME_W-1:0]       out_entry_uptime,
  output logic [SAMPLE_W-1:0]     out_entry_millivolts,
  output logic [LEVEL_W-1:0]      out_entry_level
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [WEIGHT_W-1:0] weight_r;
  logic [THR_W-1:0]    thr_r;
  logic [TIME_W-1:0]   timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r  <= WEIGHT_RST;
      thr_r     <= THR_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SMOOTHING_WEIGHT:    weight_r  <= cfg_data[WEIGHT_W-1:0];
        REG_CHANGE_THRESHOLD_MV: thr_r     <= cfg_data[THR_W-1:0];
        REG_LOG_TIMEOUT_S:       timeout_r <= cfg_data[TIME_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  // stage a: input register, stage b: result register (with ram read data)
  logic a_valid_r;
  logic out_valid_r;
  logic adv_b;     // result register can take a new transaction
  logic adv_a;     // input register can take a new transaction
  logic in_acc;
  logic commit;    // stage a transaction moves into the result register

  assign adv_b    = !out_valid_r || !out_stall;
  assign adv_a    = !a_valid_r || adv_b;
  assign in_stall = !adv_a;
  assign in_acc   = in_valid && adv_a;
  assign commit   = a_valid_r && adv_b;

  // --------------------------------------------------------------------------
  // stage a: input register
  // --------------------------------------------------------------------------
  logic                    a_mode_r;
  logic [SAMPLE_W-1:0]     a_sample_r;
  logic [LEVEL_IN_W-1:0]   a_level_r;
  logic [TIME_W-1:0]       a_uptime_r;
  logic [READ_INDEX_W-1:0] a_ridx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_mode_r   <= in_mode;
      a_sample_r <= in_sample_mv;
      a_level_r  <= in_charge_level;
      a_uptime_r <= in_uptime_s;
      a_ridx_r   <= in_read_index;
    end
  end

  // --------------------------------------------------------------------------
  // filter and logger state
  // --------------------------------------------------------------------------
  logic [FIX_W-1:0]  smooth_r,   smooth_nxt;
  logic [FIX_W-1:0]  last_v_r,   last_v_nxt;
  logic [TIME_W-1:0] last_t_r,   last_t_nxt;
  logic [LOG_AW-1:0] wpos_r,     wpos_nxt;
  logic [CNT_W-1:0]  log_cnt_r,  log_cnt_nxt;

  logic [FIX_W-1:0]  ema_fix;
  logic [FIX_W-1:0]  smooth_upd;   // filter value after this transaction
  logic [SAMPLE_W-1:0] smooth_mv;
  logic [FIX_W-1:0]  diff;
  logic [TIME_W-1:0] elapsed;
  logic              changed;
  logic              first;
  logic              timed;
  logic              log_now;      // sample appends an entry
  logic              is_sample;
  logic [LEVEL_W-1:0] level_sat;

  svcl_ema u_ema (
    .weight    (weight_r),
    .old_fix   (smooth_r),
    .sample_mv (a_sample_r),
    .new_fix   (ema_fix)
  );

  assign is_sample  = (a_mode_r == MODE_SAMPLE);
  assign smooth_upd = is_sample ? ema_fix : smooth_r;
  assign smooth_mv  = to_mv(smooth_upd);

  // absolute filtered move since the last entry
  assign diff    = (ema_fix >= last_v_r) ? ema_fix - last_v_r : last_v_r - ema_fix;
  assign changed = diff >= {thr_r, {FRAC_W{1'b0}}};
  assign first   = (log_cnt_r == '0);
  assign elapsed = a_uptime_r - last_t_r;   // wraps with the time base
  assign timed   = !first && (elapsed >= timeout_r);
  assign log_now = is_sample && (changed || first || timed);

  assign level_sat = (a_level_r > LEVEL_IN_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                         : a_level_r[LEVEL_W-1:0];

  always_comb begin
    smooth_nxt  = smooth_r;
    last_v_nxt  = last_v_r;
    last_t_nxt  = last_t_r;
    wpos_nxt    = wpos_r;
    log_cnt_nxt = log_cnt_r;
    if (commit && is_sample) begin
      smooth_nxt = ema_fix;
      if (log_now) begin
        last_v_nxt = ema_fix;
        last_t_nxt = a_uptime_r;
        wpos_nxt   = (wpos_r == LOG_AW'(LOG_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
        // full ring overwrites the oldest entry, count saturates
        if (log_cnt_r != CNT_W'(LOG_DEPTH)) begin
          log_cnt_nxt = log_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r  <= '0;
      last_v_r  <= '0;
      last_t_r  <= '0;
      wpos_r    <= '0;
      log_cnt_r <= '0;
    end else begin
      smooth_r  <= smooth_nxt;
      last_v_r  <= last_v_nxt;
      last_t_r  <= last_t_nxt;
      wpos_r    <= wpos_nxt;
      log_cnt_r <= log_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // log read address: oldest entry plus read index, modulo the ring depth
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] wpos_e;
  logic [SUM_W-1:0] cnt_e;
  logic [SUM_W-1:0] ridx_e;
  logic [SUM_W-1:0] oldest;
  logic [SUM_W-1:0] raddr_sum;
  logic [SUM_W-1:0] raddr_mod;
  logic             in_range;

  assign wpos_e    = SUM_W'(wpos_r);
  assign cnt_e     = SUM_W'(log_cnt_r);
  assign ridx_e    = SUM_W'(a_ridx_r);
  assign in_range  = ridx_e < cnt_e;
  assign oldest    = (wpos_e >= cnt_e) ? wpos_e - cnt_e
                                       : wpos_e + SUM_W'(LOG_DEPTH) - cnt_e;
  assign raddr_sum = oldest + ridx_e;
  assign raddr_mod = (raddr_sum >= SUM_W'(LOG_DEPTH)) ? raddr_sum - SUM_W'(LOG_DEPTH)
                                                      : raddr_sum;

  // --------------------------------------------------------------------------
  // log memory
  // --------------------------------------------------------------------------
  log_wr_t    log_wr;
  log_rd_t    log_rd;
  log_entry_t log_rdata;

  assign log_wr.we              = commit && log_now;
  assign log_wr.addr            = wpos_r;
  assign log_wr.data.uptime     = a_uptime_r;
  assign log_wr.data.millivolts = smooth_mv;
  assign log_wr.data.level      = level_sat;

  assign log_rd.re   = commit && !is_sample && in_range;
  assign log_rd.addr = raddr_mod[LOG_AW-1:0];

  svcl_log_ram u_log_ram (
    .clk     (clk),
    .wr      (log_wr),
    .rd      (log_rd),
    .rd_data (log_rdata)
  );

  // --------------------------------------------------------------------------
  // stage b: result register
  // --------------------------------------------------------------------------
  logic                b_logged_r;
  logic [SAMPLE_W-1:0] b_mv_r;
  logic [CNT_W-1:0]    b_cnt_r;
  logic                b_evalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_b) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      b_logged_r <= log_now;
      b_mv_r     <= smooth_mv;
      b_cnt_r    <= log_cnt_nxt;
      b_evalid_r <= !is_sample && in_range;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_logged           = b_logged_r;
  assign out_filtered_mv      = b_mv_r;
  assign out_entry_count      = b_cnt_r;
  assign out_entry_valid      = b_evalid_r;
  // entry fields read as zero unless a valid entry was fetched
  assign out_entry_uptime     = b_evalid_r ? log_rdata.uptime     : '0;
  assign out_entry_millivolts = b_evalid_r ? log_rdata.millivolts : '0;
  assign out_entry_level      = b_evalid_r ? log_rdata.level      : '0;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    log_cnt_r <= CNT_W'(LOG_DEPTH))
    else $error("log entry count above ring depth");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (a_mode_r == MODE_READ) |=>
      $stable(log_cnt_r) && $stable(wpos_r) && $stable(smooth_r))
    else $error("log read changed logger state");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    commit && log_now && (log_cnt_r != CNT_W'(LOG_DEPTH)) |=>
      log_cnt_r == $past(log_cnt_r) + 1'b1)
    else $error("appended entry not counted");

  a_entry_not_logged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> !out_logged)
    else $error("result both fetched and appended an entry");

  a_empty_reads_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (log_cnt_r == '0) |-> !log_rd.re)
    else $error("read issued on an empty log");

endmodule

/* verif/tb_smoothed_voltage_change_logger_unit.sv */
// ----------------------------------------------------------------------------
// tb_smoothed_voltage_change_logger_unit
// self-checking bench for the smoothed voltage change logger
// ----------------------------------------------------------------------------
// Sample and read transactions are sent into the block. A predictor inside the
// bench keeps its own copy of the filter, the log ring and the registers.
// Every accepted input transaction queues its predicted result. Every accepted
// result is checked field by field against the oldest prediction. Both sides
// idle at random, and one test holds the result side off for a long stretch
// so that the block fills up and stalls its input. Registers are only written
// while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_smoothed_voltage_change_logger_unit import svcl_pkg::*;;

  localparam int CLK_HALF  = 4;
  localparam int RST_CYC   = 11;
  localparam int LONG_HOLD = 80;
  localparam int MAX_GAP   = 19;
  localparam int MAX_PRINT = 200;

  // one input transaction
  typedef struct {
    logic                    mode;
    logic [SAMPLE_W-1:0]     sample_mv;
    logic [LEVEL_IN_W-1:0]   level;
    logic [TIME_W-1:0]       uptime;
    logic [READ_INDEX_W-1:0] read_index;
  } reading_t;

  // one result transaction
  typedef struct {
    logic                logged;
    logic [SAMPLE_W-1:0] filtered_mv;
    logic [CNT_W-1:0]    entry_count;
    logic                entry_valid;
    logic [TIME_W-1:0]   entry_uptime;
    logic [SAMPLE_W-1:0] entry_mv;
    logic [LEVEL_W-1:0]  entry_level;
  } log_result_t;

  // clock, reset and block ports, the driven ones known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_mode = MODE_SAMPLE;
  logic [SAMPLE_W-1:0]     in_sample_mv = '0;
  logic [LEVEL_IN_W-1:0]   in_charge_level = '0;
  logic [TIME_W-1:0]       in_uptime_s = '0;
  logic [READ_INDEX_W-1:0] in_read_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_logged;
  logic [SAMPLE_W-1:0]     out_filtered_mv;
  logic [CNT_W-1:0]        out_entry_count;
  logic                    out_entry_valid;
  logic [TIME_W-1:0]       out_entry_uptime;
  logic [SAMPLE_W-1:0]     out_entry_millivolts;
  logic [LEVEL_W-1:0]      out_entry_level;

  // predictor copy of the registers
  logic [WEIGHT_W-1:0] cur_weight    = WEIGHT_RST;
  logic [THR_W-1:0]    cur_threshold = THR_RST;
  logic [TIME_W-1:0]   cur_timeout   = TIMEOUT_RST;

  // predictor copy of the filter and the log ring
  logic [FIX_W-1:0]    mdl_smoothed    = '0;
  logic [FIX_W-1:0]    mdl_last_logged = '0;
  logic [TIME_W-1:0]   mdl_last_time   = '0;
  logic [LOG_AW-1:0]   mdl_wr_pos      = '0;
  logic [CNT_W-1:0]    mdl_count       = '0;
  logic [TIME_W-1:0]   mdl_time  [LOG_DEPTH];
  logic [SAMPLE_W-1:0] mdl_mv    [LOG_DEPTH];
  logic [LEVEL_W-1:0]  mdl_level [LOG_DEPTH];

  // predicted results still waiting for the block
  log_result_t due_log_results[$];

  int unsigned mismatch_count = 0;

  // idling control shared by both sides
  logic        no_idle = 1'b0;
  int unsigned hold_req_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned rx_wait = 0;

  // stimulus shaping
  logic [TIME_W-1:0] now_s = '0;
  int                volt_mv = 3700;

  reading_t    in_item;
  log_result_t want;

  smoothed_voltage_change_logger_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_sample_mv         (in_sample_mv),
    .in_charge_level      (in_charge_level),
    .in_uptime_s          (in_uptime_s),
    .in_read_index        (in_read_index),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_logged           (out_logged),
    .out_filtered_mv      (out_filtered_mv),
    .out_entry_count      (out_entry_count),
    .out_entry_valid      (out_entry_valid),
    .out_entry_uptime     (out_entry_uptime),
    .out_entry_millivolts (out_entry_millivolts),
    .out_entry_level      (out_entry_level)
  );

  always #(CLK_HALF) clk = ~clk;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // 13.8 fixed point to whole millivolts, half up, clamped to the field
  function automatic logic [SAMPLE_W-1:0] fixed_to_mv(input logic [FIX_W-1:0] fx);
    logic [31:0] mv;
    mv = (32'(fx) + 32'd128) >> FRAC_W;
    if (mv > 32'(MV_MAX)) begin
      mv = 32'(MV_MAX);
    end
    return mv[SAMPLE_W-1:0];
  endfunction

  // advances the model by one transaction and returns what the block must show
  function automatic log_result_t apply_reading(input reading_t rd);
    log_result_t       r;
    logic [63:0]       acc;
    logic [FIX_W-1:0]  s_fix;
    logic [FIX_W-1:0]  delta;
    logic [31:0]       w;
    logic [TIME_W-1:0] elapsed;
    logic [LOG_AW-1:0] slot;
    logic              changed;
    logic              timed;
    logic              empty;
    r = '{default: '0};
    if (rd.mode == MODE_SAMPLE) begin
      // weights above one are taken as one
      w = (32'(cur_weight) > 32'(WEIGHT_ONE)) ? 32'(WEIGHT_ONE) : 32'(cur_weight);
      s_fix = {rd.sample_mv, {FRAC_W{1'b0}}};
      // a filter that still reads zero is loaded with the sample itself
      if (mdl_smoothed == '0) begin
        mdl_smoothed = s_fix;
      end else begin
        acc = 64'(w) * 64'(s_fix) + 64'(32'(WEIGHT_ONE) - w) * 64'(mdl_smoothed) + 64'd128;
        mdl_smoothed = acc[FIX_W+FRAC_W-1:FRAC_W];
      end
      delta = (mdl_smoothed >= mdl_last_logged) ? mdl_smoothed - mdl_last_logged
                                                : mdl_last_logged - mdl_smoothed;
      changed = 32'(delta) >= (32'(cur_threshold) << FRAC_W);
      empty   = (mdl_count == '0);
      // time difference wraps modulo 2^32
      elapsed = rd.uptime - mdl_last_time;
      timed   = !empty && (elapsed >= cur_timeout);
      if (changed || empty || timed) begin
        slot = mdl_wr_pos;
        mdl_time[slot]  = rd.uptime;
        mdl_mv[slot]    = fixed_to_mv(mdl_smoothed);
        mdl_level[slot] = (rd.level > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : rd.level[LEVEL_W-1:0];
        mdl_wr_pos      = slot + 1'b1;
        // a full ring overwrites its oldest entry
        if (mdl_count < CNT_W'(LOG_DEPTH)) begin
          mdl_count = mdl_count + 1'b1;
        end
        mdl_last_logged = mdl_smoothed;
        mdl_last_time   = rd.uptime;
        r.logged        = 1'b1;
      end
    end else if (CNT_W'(rd.read_index) < mdl_count) begin
      // index counted from the oldest entry
      slot = mdl_wr_pos - mdl_count[LOG_AW-1:0] + rd.read_index;
      r.entry_valid  = 1'b1;
      r.entry_uptime = mdl_time[slot];
      r.entry_mv     = mdl_mv[slot];
      r.entry_level  = mdl_level[slot];
    end
    r.filtered_mv = fixed_to_mv(mdl_smoothed);
    r.entry_count = mdl_count;
    return r;
  endfunction

  // every input transaction accepted at this edge gets its prediction queued
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      in_item = '{mode: in_mode, sample_mv: in_sample_mv, level: in_charge_level,
                  uptime: in_uptime_s, read_index: in_read_index};
      due_log_results.push_back(apply_reading(in_item));
    end
  end

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINT) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      report_mismatch($sformatf("%s expected %0d got %0d", name, exp_v, got_v));
    end
  endtask

  // each accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (due_log_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing predicted, filtered_mv %0d",
                                  out_filtered_mv));
      end else begin
        want = due_log_results.pop_front();
        compare_field("logged", 32'(want.logged), 32'(out_logged));
        compare_field("filtered_mv", 32'(want.filtered_mv), 32'(out_filtered_mv));
        compare_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        compare_field("entry_valid", 32'(want.entry_valid), 32'(out_entry_valid));
        compare_field("entry_uptime", want.entry_uptime, out_entry_uptime);
        compare_field("entry_millivolts", 32'(want.entry_mv), 32'(out_entry_millivolts));
        compare_field("entry_level", 32'(want.entry_level), 32'(out_entry_level));
      end
    end
  end

  // receiver: after each result it stalls for a random pause unless no_idle is set;
  // a new hold request makes it stall for a long stretch counted here
  always @(posedge clk) begin
    if (hold_req_seq != hold_seen) begin
      hold_seen = hold_req_seq;
      rx_wait   = LONG_HOLD;
    end else if (rst_n && out_valid === 1'b1 && !out_stall && rx_wait == 0) begin
      rx_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
    out_stall <= (rx_wait != 0);
  end

  // ------------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------------

  // offers one transaction after a random pause and returns at the edge that
  // takes it; valid stays high so a following transaction can go back to back
  task automatic send_reading(input reading_t rd);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= rd.mode;
    in_sample_mv    <= rd.sample_mv;
    in_charge_level <= rd.level;
    in_uptime_s     <= rd.uptime;
    in_read_index   <= rd.read_index;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] mv, input logic [LEVEL_IN_W-1:0] lvl,
                             input logic [TIME_W-1:0] up);
    reading_t rd;
    // read index is a don't care on samples
    rd = '{mode: MODE_SAMPLE, sample_mv: mv, level: lvl, uptime: up,
           read_index: READ_INDEX_W'($urandom())};
    send_reading(rd);
  endtask

  task automatic send_read(input logic [READ_INDEX_W-1:0] idx);
    reading_t rd;
    // sample fields are don't cares on reads
    rd = '{mode: MODE_READ, sample_mv: SAMPLE_W'($urandom()), level: LEVEL_IN_W'($urandom()),
           uptime: $urandom(), read_index: idx};
    send_reading(rd);
  endtask

  // one in four a read, else a slow battery voltage walk with steady time, some wild values
  function automatic reading_t random_reading();
    reading_t rd;
    int       top;
    rd.level = LEVEL_IN_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      rd.mode      = MODE_READ;
      rd.sample_mv = SAMPLE_W'($urandom());
      rd.uptime    = $urandom();
      top = int'(mdl_count) - 1;
      if (top >= 0 && $urandom_range(0, 3) != 0) begin
        rd.read_index = READ_INDEX_W'($urandom_range(0, top));
      end else begin
        rd.read_index = READ_INDEX_W'($urandom_range(0, 255));
      end
    end else begin
      rd.mode = MODE_SAMPLE;
      if ($urandom_range(0, 9) == 0) begin
        volt_mv = $urandom_range(0, MV_MAX);
      end else begin
        volt_mv = volt_mv + int'($urandom_range(0, 60)) - 30;
        volt_mv = (volt_mv < 0) ? 0 : (volt_mv > MV_MAX) ? MV_MAX : volt_mv;
      end
      rd.sample_mv = SAMPLE_W'(volt_mv);
      if ($urandom_range(0, 39) == 0) begin
        now_s = $urandom();
      end else begin
        now_s = now_s + $urandom_range(0, 600);
      end
      rd.uptime     = now_s;
      rd.read_index = READ_INDEX_W'($urandom());
    end
    return rd;
  endfunction

  // stops offering and waits until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    // the prediction of the last accepted transaction is queued by now
    @(posedge clk);
    while (due_log_results.size() != 0) @(posedge clk);
    // margin after the pipeline has drained
    repeat (4) @(posedge clk);
  endtask

  // one register write; valid stays high for back to back writes
  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SMOOTHING_WEIGHT:    cur_weight    = val[WEIGHT_W-1:0];
      REG_CHANGE_THRESHOLD_MV: cur_threshold = val[THR_W-1:0];
      REG_LOG_TIMEOUT_S:       cur_timeout   = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // only called once the block is idle
  task automatic apply_settings(input logic [WEIGHT_W-1:0] w, input logic [THR_W-1:0] thr,
                                input logic [TIME_W-1:0] tmo);
    put_register(REG_SMOOTHING_WEIGHT, CFG_DATA_W'(w));
    put_register(REG_CHANGE_THRESHOLD_MV, CFG_DATA_W'(thr));
    put_register(REG_LOG_TIMEOUT_S, tmo);
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset register values: empty log reads, zero sample, first load, levels
  task automatic test_empty_log_and_first_sample();
    send_read(8'd0);
    send_read(8'd255);
    // zero sample leaves the filter at zero but still makes the first entry
    send_sample(13'd0, 8'd255, 32'd0);
    // filter still zero, so loaded with the full scale sample
    send_sample(13'd8191, 8'd101, 32'd5);
    send_sample(13'd0, 8'd100, 32'd10);
    send_sample(13'd4000, 8'd0, 32'hFFFF_FFFF);
    send_read(8'd0);
    send_read(8'd3);
    // one past the last entry
    send_read(8'd4);
    wait_idle();
  endtask

  // elapsed time across the 32 bit wrap, zero and maximum timeout
  task automatic test_timeout_and_wrap();
    apply_settings(WEIGHT_RST, 13'd8191, 32'h20);
    send_sample(13'd3000, 8'd50, 32'hFFFF_FFF0);
    send_sample(13'd3000, 8'd50, 32'h0000_000F);
    send_sample(13'd3000, 8'd50, 32'h0000_0010);
    wait_idle();
    apply_settings(WEIGHT_RST, 13'd8191, 32'd0);
    send_sample(13'd3001, 8'd60, 32'h0000_0010);
    wait_idle();
    apply_settings(WEIGHT_RST, 13'd8191, 32'hFFFF_FFFF);
    send_sample(13'd3002, 8'd70, 32'h0000_0015);
    wait_idle();
    now_s = 32'h0000_0015;
  endtask

  // weight zero freezes the filter, one and above one track the sample
  task automatic test_weight_extremes();
    apply_settings(9'd0, 13'd0, 32'hFFFF_FFFF);
    send_sample(13'd8191, 8'd90, now_s + 1);
    wait_idle();
    apply_settings(9'd256, 13'd8191, 32'hFFFF_FFFF);
    send_sample(13'd1234, 8'd30, now_s + 2);
    wait_idle();
    apply_settings(9'd511, 13'd1, 32'hFFFF_FFFF);
    send_sample(13'd100, 8'd20, now_s + 3);
    // exactly one millivolt step meets a threshold of one
    send_sample(13'd101, 8'd20, now_s + 4);
    wait_idle();
  endtask

  // threshold zero logs every sample, so the ring fills and wraps
  task automatic test_ring_wrap();
    reading_t rd;
    apply_settings(9'($urandom_range(0, 511)), 13'd0, $urandom());
    repeat (300) begin
      rd = random_reading();
      if (rd.mode == MODE_SAMPLE) begin
        send_reading(rd);
      end else begin
        send_sample(SAMPLE_W'(volt_mv), rd.level, now_s);
      end
    end
    send_read(8'd0);
    send_read(8'd255);
    repeat (20) send_read(READ_INDEX_W'($urandom()));
    wait_idle();
  endtask

  // result side holds off while the sender keeps offering back to back
  task automatic test_back_pressure();
    apply_settings(WEIGHT_RST, 13'd5, 32'd600);
    no_idle      <= 1'b1;
    hold_req_seq <= hold_req_seq + 1;
    repeat (48) send_reading(random_reading());
    no_idle <= 1'b0;
    wait_idle();
  endtask

  // several register settings, extremes included, random traffic in each
  task automatic test_random_phases();
    logic [WEIGHT_W-1:0] w;
    logic [THR_W-1:0]    thr;
    logic [TIME_W-1:0]   tmo;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0:       w = 9'd0;
        1:       w = 9'd256;
        2:       w = 9'd511;
        3:       w = WEIGHT_RST;
        default: w = 9'($urandom_range(0, 511));
      endcase
      case ($urandom_range(0, 5))
        0:       thr = 13'd0;
        1:       thr = 13'd8191;
        2:       thr = THR_RST;
        default: thr = 13'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 5))
        0:       tmo = 32'd0;
        1:       tmo = 32'hFFFF_FFFF;
        2:       tmo = TIMEOUT_RST;
        3:       tmo = $urandom();
        default: tmo = $urandom_range(1, 900);
      endcase
      apply_settings(w, thr, tmo);
      // odd phases run without any idling on either side
      no_idle <= ph[0];
      repeat (130) send_reading(random_reading());
      no_idle <= 1'b0;
      wait_idle();
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (RST_CYC) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_log_and_first_sample();
    test_timeout_and_wrap();
    test_weight_extremes();
    test_ring_wrap();
    test_back_pressure();
    test_random_phases();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(3_200_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/svcl_pkg.sv
rtl/svcl_ema.sv
rtl/svcl_log_ram.sv
rtl/smoothed_voltage_change_logger_unit.sv
verif/tb_smoothed_voltage_change_logger_unit.sv
